FILE: sv/tmed_pkg.sv
// Shared types and compare helpers for the temporal median-of-nine filter.
// No dependencies; every other file in this block imports this package.
package tmed_pkg;

  localparam int unsigned SAMPLE_W     = 8;
  localparam int unsigned SAMPLE_COUNT = 9;
  localparam int unsigned MEDIAN_RANK  = 4;

  typedef logic [SAMPLE_W-1:0] sample_t;

  function automatic sample_t min2(input sample_t a, input sample_t b);
    return (a < b) ? a : b;
  endfunction

  function automatic sample_t max2(input sample_t a, input sample_t b);
    return (a < b) ? b : a;
  endfunction

  function automatic sample_t min3(input sample_t a, input sample_t b, input sample_t c);
    return min2(min2(a, b), c);
  endfunction

  function automatic sample_t max3(input sample_t a, input sample_t b, input sample_t c);
    return max2(max2(a, b), c);
  endfunction

  // Middle of three: the larger of the pair minimum and the smaller of the rest.
  function automatic sample_t med3(input sample_t a, input sample_t b, input sample_t c);
    return max2(min2(a, b), min2(max2(a, b), c));
  endfunction

endpackage

FILE: sv/tmed_sort3.sv
// Registered three-input sorter used for the row-sort stage.
// Depends on tmed_pkg for the sample type and compare helpers.
module tmed_sort3 (
  input  logic             clk,
  input  tmed_pkg::sample_t a,
  input  tmed_pkg::sample_t b,
  input  tmed_pkg::sample_t c,
  output tmed_pkg::sample_t lo,
  output tmed_pkg::sample_t mid,
  output tmed_pkg::sample_t hi
);
  import tmed_pkg::*;

  sample_t lo_r, mid_r, hi_r;
  sample_t lo_nxt, mid_nxt, hi_nxt;

  always_comb begin
    lo_nxt  = min3(a, b, c);
    mid_nxt = med3(a, b, c);
    hi_nxt  = max3(a, b, c);
  end

  // Payload only; validity travels beside it in the parent.
  always_ff @(posedge clk) begin
    lo_r  <= lo_nxt;
    mid_r <= mid_nxt;
    hi_r  <= hi_nxt;
  end

  assign lo  = lo_r;
  assign mid = mid_r;
  assign hi  = hi_r;

endmodule

FILE: sv/temporal_median_of_nine.sv
// Top level of the temporal median-of-nine filter: handshake, valid pipeline
// and the three compare stages. Depends on tmed_pkg and tmed_sort3.
//
// The block takes one request of nine 8-bit channel samples (the same pixel
// in nine frames) and returns their median, the fifth smallest value. busy is
// held low, so a request is accepted in every cycle that start is high. The
// median is shown on out_median_value with out_valid high for exactly one
// cycle, once the request has passed the three register stages of the
// median network. Throughput is one median per clock. The stages are a sort
// of each group of three samples, then the maximum of the minimums, the
// median of the middles and the minimum of the maximums, then the median of
// those three. Results are never held back, since the receiver takes each one
// in the cycle it is shown, and requests in flight are unaffected by new ones
// arriving behind them.
module temporal_median_of_nine (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  tmed_pkg::sample_t in_sample_0,
  input  tmed_pkg::sample_t in_sample_1,
  input  tmed_pkg::sample_t in_sample_2,
  input  tmed_pkg::sample_t in_sample_3,
  input  tmed_pkg::sample_t in_sample_4,
  input  tmed_pkg::sample_t in_sample_5,
  input  tmed_pkg::sample_t in_sample_6,
  input  tmed_pkg::sample_t in_sample_7,
  input  tmed_pkg::sample_t in_sample_8,
  output logic              out_valid,
  output tmed_pkg::sample_t out_median_value
);
  import tmed_pkg::*;

  // The pipeline never stalls, so a request can always be taken.
  logic accept;
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Valid bits, one per stage, moving in step with the data.
  logic v1_r, v2_r, v3_r;
  logic v1_nxt, v2_nxt, v3_nxt;

  always_comb begin
    v1_nxt = accept;
    v2_nxt = v1_r;
    v3_nxt = v2_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
      v3_r <= v3_nxt;
    end
  end

  // Stage 1: sort each row of three samples.
  sample_t lo0, mid0, hi0;
  sample_t lo1, mid1, hi1;
  sample_t lo2, mid2, hi2;

  tmed_sort3 u_row0 (
    .clk (clk), .a (in_sample_0), .b (in_sample_1), .c (in_sample_2),
    .lo  (lo0), .mid (mid0), .hi (hi0)
  );
  tmed_sort3 u_row1 (
    .clk (clk), .a (in_sample_3), .b (in_sample_4), .c (in_sample_5),
    .lo  (lo1), .mid (mid1), .hi (hi1)
  );
  tmed_sort3 u_row2 (
    .clk (clk), .a (in_sample_6), .b (in_sample_7), .c (in_sample_8),
    .lo  (lo2), .mid (mid2), .hi (hi2)
  );

  // Stage 2: across the rows, the largest minimum, the middle median and the
  // smallest maximum. The overall median is the median of these three.
  sample_t low_r, center_r, high_r;
  sample_t low_nxt, center_nxt, high_nxt;

  always_comb begin
    low_nxt    = max3(lo0, lo1, lo2);
    center_nxt = med3(mid0, mid1, mid2);
    high_nxt   = min3(hi0, hi1, hi2);
  end

  always_ff @(posedge clk) begin
    low_r    <= low_nxt;
    center_r <= center_nxt;
    high_r   <= high_nxt;
  end

  // Stage 3: final median of three, registered straight onto the output.
  sample_t median_r;
  sample_t median_nxt;

  always_comb begin
    median_nxt = med3(low_r, center_r, high_r);
  end

  always_ff @(posedge clk) begin
    median_r <= median_nxt;
  end

  assign out_valid        = v3_r;
  assign out_median_value = median_r;

endmodule

FILE: sv/tmed_checker.sv
// Port-level checker for the temporal median-of-nine filter, bound to its top.
// Depends on tmed_pkg and on the temporal_median_of_nine port list.
module tmed_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              start,
  input logic              busy,
  input tmed_pkg::sample_t in_sample_0,
  input tmed_pkg::sample_t in_sample_1,
  input tmed_pkg::sample_t in_sample_2,
  input tmed_pkg::sample_t in_sample_3,
  input tmed_pkg::sample_t in_sample_4,
  input tmed_pkg::sample_t in_sample_5,
  input tmed_pkg::sample_t in_sample_6,
  input tmed_pkg::sample_t in_sample_7,
  input tmed_pkg::sample_t in_sample_8,
  input logic              out_valid,
  input tmed_pkg::sample_t out_median_value
);
  import tmed_pkg::*;

  // The filter never pushes back on a request.
  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
    !busy)
    else $error("busy raised");

  // Every accepted request yields a result.
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##3 out_valid)
    else $error("result missing three cycles after request");

  // No result appears without an earlier accepted request.
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, 3))
    else $error("result without request");

  // The result has at least five samples at or below it and five at or above.
  a_is_median: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |->
      ($countones({$past(in_sample_0, 3) <= out_median_value,
                   $past(in_sample_1, 3) <= out_median_value,
                   $past(in_sample_2, 3) <= out_median_value,
                   $past(in_sample_3, 3) <= out_median_value,
                   $past(in_sample_4, 3) <= out_median_value,
                   $past(in_sample_5, 3) <= out_median_value,
                   $past(in_sample_6, 3) <= out_median_value,
                   $past(in_sample_7, 3) <= out_median_value,
                   $past(in_sample_8, 3) <= out_median_value}) >= MEDIAN_RANK + 1) &&
      ($countones({$past(in_sample_0, 3) >= out_median_value,
                   $past(in_sample_1, 3) >= out_median_value,
                   $past(in_sample_2, 3) >= out_median_value,
                   $past(in_sample_3, 3) >= out_median_value,
                   $past(in_sample_4, 3) >= out_median_value,
                   $past(in_sample_5, 3) >= out_median_value,
                   $past(in_sample_6, 3) >= out_median_value,
                   $past(in_sample_7, 3) >= out_median_value,
                   $past(in_sample_8, 3) >= out_median_value}) >= MEDIAN_RANK + 1))
    else $error("result is not the median of its request");

endmodule

bind temporal_median_of_nine tmed_checker u_tmed_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .start            (start),
  .busy             (busy),
  .in_sample_0      (in_sample_0),
  .in_sample_1      (in_sample_1),
  .in_sample_2      (in_sample_2),
  .in_sample_3      (in_sample_3),
  .in_sample_4      (in_sample_4),
  .in_sample_5      (in_sample_5),
  .in_sample_6      (in_sample_6),
  .in_sample_7      (in_sample_7),
  .in_sample_8      (in_sample_8),
  .out_valid        (out_valid),
  .out_median_value (out_median_value)
);
